@@ sv/spq_pkg.sv @@
// Shared types, codes and defaults for the sorted-insert priority queue.
package spq_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 16;

  localparam int ID_W  = 16;
  localparam int PRI_W = 8;
  localparam int DUR_W = 16;
  localparam int OCC_W = 5;
  localparam int ST_W  = 2;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
    logic [DUR_W-1:0] dur;
  } spq_rec_t;

  typedef struct packed {
    logic enq;
    logic deq;
  } spq_ctl_t;

endpackage

@@ sv/spq_cell.sv @@
// One queue slot: holds a record and shifts, inserts or keeps it each cycle.
module spq_cell
  import spq_pkg::*;
(
  input  logic     clk,
  input  spq_ctl_t ctl,
  input  logic     occupied,
  input  spq_rec_t new_rec,
  input  spq_rec_t left_rec,
  input  logic     left_ahead,
  input  spq_rec_t right_rec,
  output spq_rec_t ent,
  output logic     ahead
);

  spq_rec_t ent_r;
  spq_rec_t ent_nxt;

  assign ahead = occupied && (ent_r.pri >= new_rec.pri);
  assign ent   = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.enq) begin
      if (!ahead) begin
        ent_nxt = left_ahead ? new_rec : left_rec;
      end
    end else if (ctl.deq) begin
      ent_nxt = right_rec;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

@@ sv/sorted_insert_priority_queue_unit.sv @@
// Top level of the sorted-insert priority queue built from a chain of slot cells.
// Every enqueue or dequeue request is accepted by the cell chain, and its result is
// presented in the next cycle from an output register; a new request is taken
// every cycle as long as the result side keeps draining. The rate is set by
// the chain of QUEUE_DEPTH cells, which all compare against the incoming
// priority and shift toward or away from the head in the same cycle. Records
// are held in descending priority, ties in arrival order. An enqueue to a full
// queue returns status 1, a dequeue from an empty queue returns status 2;
// record fields of a result are zero unless it is a successful dequeue.
module sorted_insert_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_command,
  input  logic [ID_W-1:0]  in_job_id,
  input  logic [PRI_W-1:0] in_job_priority,
  input  logic [DUR_W-1:0] in_job_duration,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [ST_W-1:0]  out_status,
  output logic [ID_W-1:0]  out_id,
  output logic [PRI_W-1:0] out_priority,
  output logic [DUR_W-1:0] out_duration,
  output logic [OCC_W-1:0] out_occupancy
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             vld_r;
  logic             vld_nxt;
  logic [ST_W-1:0]  st_r;
  logic [ST_W-1:0]  st_nxt;
  spq_rec_t         res_r;
  spq_rec_t         res_nxt;
  logic [OCC_W-1:0] occ_r;
  logic [OCC_W-1:0] occ_nxt;
  logic [CNT_W+OCC_W-1:0] cnt_ext;

  logic     take;
  logic     full;
  logic     empty;
  spq_ctl_t ctl;
  spq_rec_t new_rec;

  spq_rec_t ents  [QUEUE_DEPTH];
  logic     aheads[QUEUE_DEPTH];

  assign in_stall = vld_r && out_stall;
  assign take     = in_valid && !in_stall;
  assign full     = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign ctl.enq  = take && (in_command == CMD_ENQ) && !full;
  assign ctl.deq  = take && (in_command == CMD_DEQ) && !empty;
  assign new_rec  = '{id: in_job_id, pri: in_job_priority, dur: in_job_duration};

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    spq_rec_t left_rec;
    spq_rec_t right_rec;
    logic     left_ahead;

    if (i == 0) begin : g_head
      assign left_rec   = new_rec;
      assign left_ahead = 1'b0;
    end else begin : g_mid
      assign left_rec   = ents[i-1];
      assign left_ahead = aheads[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_rec = ents[i];
    end else begin : g_body
      assign right_rec = ents[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (CNT_W'(i) < cnt_r),
      .new_rec    (new_rec),
      .left_rec   (left_rec),
      .left_ahead (left_ahead),
      .right_rec  (right_rec),
      .ent        (ents[i]),
      .ahead      (aheads[i])
    );
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.enq) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (ctl.deq) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  assign cnt_ext = {{OCC_W{1'b0}}, cnt_nxt};

  always_comb begin
    vld_nxt = vld_r && out_stall;
    st_nxt  = st_r;
    res_nxt = res_r;
    occ_nxt = occ_r;
    if (take) begin
      vld_nxt = 1'b1;
      occ_nxt = cnt_ext[OCC_W-1:0];
      res_nxt = '0;
      if (in_command == CMD_ENQ) begin
        st_nxt = full ? ST_FULL : ST_OK;
      end else begin
        st_nxt = empty ? ST_EMPTY : ST_OK;
        if (!empty) begin
          res_nxt = ents[0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      vld_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      vld_r <= vld_nxt;
    end
    st_r  <= st_nxt;
    res_r <= res_nxt;
    occ_r <= occ_nxt;
  end

  assign out_valid     = vld_r;
  assign out_status    = st_r;
  assign out_id        = res_r.id;
  assign out_priority  = res_r.pri;
  assign out_duration  = res_r.dur;
  assign out_occupancy = occ_r;

endmodule
